>>> design/dofq_pkg.sv
// Package: shared types, widths and request codes of the drop-oldest frame queue.
package dofq_pkg;

    localparam int TAG_W  = 32;
    localparam int REQ_W  = 2;
    localparam int OCC_W  = 5;
    localparam int CAP_W  = 5;
    localparam int DROP_W = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_PUSH        = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TAKE_OLDEST = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TAKE_LATEST = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR       = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [TAG_W-1:0] frame_tag;
    } req_t;

    typedef struct packed {
        logic              frame_valid;
        logic [TAG_W-1:0]  frame_out;
        logic              overwrote_oldest;
        logic [OCC_W-1:0]  occupancy;
        logic [DROP_W-1:0] dropped_total;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic load_rsp;
    } ctl_cmd_t;

endpackage

>>> design/drop_oldest_frame_queue.sv
// Top level: drop-oldest frame descriptor queue.
//
// Request channel (req_valid/req_ready/req_data) takes one beat per request:
// push, take oldest, take latest or clear. Each request yields exactly one
// response beat on rsp_valid/rsp_ready/rsp_data with the returned descriptor,
// overwrite flag, occupancy and 64-bit wrapping drop total after the request.
// Capacity is written on cfg_valid/cfg_ready/cfg_data (always ready); 0 acts
// as 1 and values above MAX_DEPTH act as MAX_DEPTH. Write it only when idle.
// The store read is registered with the request's result, and the response
// register is then loaded, raising rsp_valid. The next request is taken only
// after that load, so only one request is in the datapath at a time.
// A response waiting in the output register does not block the next request;
// that request's result waits in the datapath until the output frees up, and
// req_ready stays low meanwhile.
// Reset clears the queue, the drop total and the response valid, and sets
// capacity to 16. The descriptor store is not cleared; no unwritten entry is
// ever returned.
module drop_oldest_frame_queue #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  dofq_pkg::req_t             req_data,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output dofq_pkg::rsp_t             rsp_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dofq_pkg::CAP_W-1:0] cfg_data
);
    import dofq_pkg::*;

    ctl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    dofq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    dofq_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .rsp_data (rsp_data)
    );

endmodule

>>> design/dofq_ctrl.sv
// Controller: request/response sequencing and output register valid.
module dofq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dofq_pkg::ctl_cmd_t cmd
);
    import dofq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic rsp_free;

    assign rsp_free     = !rsp_valid_reg || rsp_ready;
    assign req_ready    = (state_reg == S_IDLE);
    assign cmd.accept   = req_valid && (state_reg == S_IDLE);
    assign cmd.load_rsp = (state_reg == S_RESP) && rsp_free;
    assign rsp_valid    = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !cmd.accept)
        else $error("accept in two consecutive cycles");
    a_resp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) && !rsp_free |=> (state_reg == S_RESP) && rsp_valid_reg)
        else $error("pending result lost while output stalled");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rsp |=> rsp_valid_reg)
        else $error("loaded beat not presented");
`endif

endmodule

>>> design/dofq_dp.sv
// Datapath: ring store, head/count/drop registers, capacity register, result register.
module dofq_dp #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dofq_pkg::ctl_cmd_t          cmd,
    input  dofq_pkg::req_t              req_data,
    input  logic                        cfg_we,
    input  logic [dofq_pkg::CAP_W-1:0]  cfg_data,
    output dofq_pkg::rsp_t              rsp_data
);
    import dofq_pkg::*;

    localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_RAW = $clog2(MAX_DEPTH + 1);
    localparam int CNT_W   = (CNT_RAW > CAP_W) ? CNT_RAW : CAP_W;
    localparam int SUM_W   = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(MAX_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAX_DEPTH);

    logic [TAG_W-1:0] mem [MAX_DEPTH];

    logic [IDX_W-1:0]  head_reg,  head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DROP_W-1:0] drop_reg,  drop_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [TAG_W-1:0]  rd_data_reg;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_over_reg,  pend_over_next;
    rsp_t              rsp_reg;

    logic [CNT_W-1:0]  cap_ext;
    logic [CNT_W-1:0]  cap_eff;
    logic              full;
    logic [IDX_W-1:0]  head_a;
    logic [CNT_W-1:0]  count_a;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  rd_addr;

    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
        return r[IDX_W-1:0];
    endfunction

    assign cap_ext = CNT_W'(cap_reg);
    assign cap_eff = (cap_ext == '0) ? CNT_W'(1) :
                     (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign full    = (count_reg >= cap_eff);
    assign head_a  = full ? wrap(SUM_W'(head_reg) + SUM_W'(1)) : head_reg;
    assign count_a = full ? (count_reg - CNT_W'(1)) : count_reg;
    assign wr_addr = wrap(SUM_W'(head_a) + SUM_W'(count_a));

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        pend_valid_next = 1'b0;
        pend_over_next  = 1'b0;
        wr_en           = 1'b0;
        rd_addr         = head_reg;
        unique case (req_data.req_type)
            REQ_PUSH:
            begin
                wr_en          = 1'b1;
                head_next      = head_a;
                count_next     = count_a + CNT_W'(1);
                pend_over_next = full;
                if (full)
                begin
                    drop_next = drop_reg + DROP_W'(1);
                end
            end
            REQ_TAKE_OLDEST:
            begin
                if (count_reg != '0)
                begin
                    pend_valid_next = 1'b1;
                    head_next       = wrap(SUM_W'(head_reg) + SUM_W'(1));
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            REQ_TAKE_LATEST:
            begin
                rd_addr = wrap(SUM_W'(head_reg) + SUM_W'(count_reg) - SUM_W'(1));
                if (count_reg != '0)
                begin
                    pend_valid_next = 1'b1;
                    drop_next       = drop_reg + DROP_W'(count_reg - CNT_W'(1));
                    count_next      = '0;
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[wr_addr] <= req_data.frame_tag;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            drop_reg       <= '0;
            cap_reg        <= CAP_RESET;
            pend_valid_reg <= 1'b0;
            pend_over_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                head_reg       <= head_next;
                count_reg      <= count_next;
                drop_reg       <= drop_next;
                pend_valid_reg <= pend_valid_next;
                pend_over_reg  <= pend_over_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg.frame_valid      <= pend_valid_reg;
            rsp_reg.frame_out        <= pend_valid_reg ? rd_data_reg : '0;
            rsp_reg.overwrote_oldest <= pend_over_reg;
            rsp_reg.occupancy        <= OCC_W'(count_reg);
            rsp_reg.dropped_total    <= drop_reg;
        end
    end

    assign rsp_data = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");
    a_empty_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && (req_data.req_type == REQ_CLEAR ||
                       req_data.req_type == REQ_TAKE_LATEST) |=> count_reg == '0)
        else $error("queue not empty after clear or take-latest");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && req_data.req_type == REQ_PUSH && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push below capacity did not add an entry");
`endif

endmodule
